### rtl/core/epc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types and constants for the echo pulse capture and zoning block.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int CAP_W     = 16;  // capture value field
    localparam int OVF_W     = 16;  // saturating overflow counters
    localparam int WID_W     = 32;  // pulse widths and thresholds
    localparam int CH_W      = 2;   // channel field
    localparam int CFG_IDX_W = 3;   // register index on the config channel

    localparam logic [OVF_W-1:0] OVF_MAX = 16'hFFFF;

    // Register reset values, in counter ticks (58 ticks per cm)
    localparam logic [WID_W-1:0] RST_MIN_VALID = 32'(58 * 2);
    localparam logic [WID_W-1:0] RST_MAX_VALID = 32'(58 * 400);
    localparam logic [WID_W-1:0] RST_NEAR      = 32'(58 * 50);
    localparam logic [WID_W-1:0] RST_MID       = 32'(58 * 100);
    localparam logic [WID_W-1:0] RST_FAR       = 32'(58 * 150);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE    = 3'd0,
        CFG_MIN_VALID = 3'd1,
        CFG_MAX_VALID = 3'd2,
        CFG_NEAR      = 3'd3,
        CFG_MID       = 3'd4,
        CFG_FAR       = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ZONE_NONE   = 3'd0,
        ZONE_NEAR   = 3'd1,
        ZONE_MID    = 3'd2,
        ZONE_FAR    = 3'd3,
        ZONE_SILENT = 3'd4
    } zone_t;

    typedef enum logic {
        ACT_OVERFLOW = 1'b0,
        ACT_CAPTURE  = 1'b1
    } action_t;

    typedef struct packed {
        action_t           action;
        logic [CH_W-1:0]   channel;
        logic              pin_level;
        logic [CAP_W-1:0]  capture_value;
    } evt_t;

    typedef struct packed {
        logic [CH_W-1:0]   out_channel;
        logic [WID_W-1:0]  width_ticks;
        logic              measured;
    } chan_result_t;

    typedef struct packed {
        logic              active;
        logic [WID_W-1:0]  min_valid;
        logic [WID_W-1:0]  max_valid;
        logic [WID_W-1:0]  near_limit;
        logic [WID_W-1:0]  mid_limit;
        logic [WID_W-1:0]  far_limit;
    } zone_cfg_t;

endpackage
`default_nettype wire

### rtl/core/echo_pulse_capture_proximity_zone_top.sv
`default_nettype none
// Path: a beat accepted on s_axis passes the input register, the channel
//   state stage and the zone stage in turn before it is presented on m_axis.
// Throughput: one event per cycle unless a stalled result beat on m_axis holds the pipeline.
// Reset: synchronous active-low aresetn clears all channel state, empties the
//   pipeline and loads the zoning registers with their default thresholds.
// ----------------------------------------------------------------------------
// echo_pulse_capture_proximity_zone_top
// Multi-channel echo pulse-width capture with nearest-distance beep zoning.
// ----------------------------------------------------------------------------
module echo_pulse_capture_proximity_zone_top #(
    parameter int NUM_CHANNELS = 3,
    parameter int COUNTER_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // event stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,  // channel[1:0], pin_level[2],
                                             // capture_value[18:3], zero pad
    input  wire logic         s_axis_tuser,  // action[0]
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata,  // out_channel[1:0],
                                             // width_ticks[33:2], zone[36:34], zero pad
    output logic              m_axis_tuser,  // measured[0]
    // register writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import epc_pkg::*;

    // ---------------- configuration registers ----------------
    zone_cfg_t cfg_reg, cfg_next;

    // Always take writes; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ACTIVE:    cfg_next.active     = cfg_data[0];
                CFG_MIN_VALID: cfg_next.min_valid  = cfg_data;
                CFG_MAX_VALID: cfg_next.max_valid  = cfg_data;
                CFG_NEAR:      cfg_next.near_limit = cfg_data;
                CFG_MID:       cfg_next.mid_limit  = cfg_data;
                CFG_FAR:       cfg_next.far_limit  = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active     <= 1'b0;
            cfg_reg.min_valid  <= RST_MIN_VALID;
            cfg_reg.max_valid  <= RST_MAX_VALID;
            cfg_reg.near_limit <= RST_NEAR;
            cfg_reg.mid_limit  <= RST_MID;
            cfg_reg.far_limit  <= RST_FAR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- input register ----------------
    // Hold the accepted beat until the channel stage takes it.
    logic          in_vld_reg, in_vld_next;
    evt_t          in_evt_reg, in_evt_next;
    evt_t          s_evt;
    logic          chan_ready;

    always_comb begin
        s_evt.action        = action_t'(s_axis_tuser);
        s_evt.channel       = s_axis_tdata[1:0];
        s_evt.pin_level     = s_axis_tdata[2];
        s_evt.capture_value = s_axis_tdata[18:3];
    end

    assign s_axis_tready = !in_vld_reg || chan_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        in_evt_next = in_evt_reg;
        if (s_axis_tready) begin
            in_vld_next = s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_evt_next = s_evt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_evt_reg <= in_evt_next;
    end

    // ---------------- channel state stage ----------------
    logic              mid_valid;
    logic              zone_ready;
    chan_result_t      mid_res;
    logic [WID_W-1:0]  widths [NUM_CHANNELS];

    epc_chan #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_chan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_vld_reg),
        .in_evt    (in_evt_reg),
        .in_ready  (chan_ready),
        .out_valid (mid_valid),
        .out_res   (mid_res),
        .out_ready (zone_ready),
        .widths    (widths)
    );

    // ---------------- zoning and output stage ----------------
    // The zone reads the widths as left by the beat now in the channel
    // stage; the next beat updates them on the same edge the zone is taken.
    chan_result_t      out_res;
    logic [2:0]        out_zone;

    epc_zone #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_zone (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_res    (mid_res),
        .in_ready  (zone_ready),
        .widths    (widths),
        .cfg       (cfg_reg),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_zone  (out_zone),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, out_zone, out_res.width_ticks, out_res.out_channel};
    assign m_axis_tuser = out_res.measured;

    // back-pressure on the input only ever comes from a stalled result beat
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire

### rtl/core/epc_chan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epc_chan
// Per-channel capture state: start counts, overflow counts, pulse widths.
// Updates state for one event per cycle unless out_ready stalls a held result, and registers the channel result.
// ----------------------------------------------------------------------------
module epc_chan #(
    parameter int NUM_CHANNELS = 3,
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    input  wire epc_pkg::evt_t                in_evt,
    output logic                              in_ready,
    output logic                              out_valid,
    output epc_pkg::chan_result_t             out_res,
    input  wire logic                         out_ready,
    output logic [epc_pkg::WID_W-1:0]         widths [NUM_CHANNELS]
);
    import epc_pkg::*;

    localparam logic [31:0] CNT_MASK = (COUNTER_BITS >= 32) ? 32'hFFFF_FFFF
                                     : ((32'd1 << COUNTER_BITS) - 32'd1);
    localparam logic [CAP_W-1:0] CAP_MASK = CNT_MASK[CAP_W-1:0];

    logic [CAP_W-1:0]  start_reg  [NUM_CHANNELS];
    logic [CAP_W-1:0]  start_next [NUM_CHANNELS];
    logic [OVF_W-1:0]  ovf_reg    [NUM_CHANNELS];
    logic [OVF_W-1:0]  ovf_next   [NUM_CHANNELS];
    logic [WID_W-1:0]  width_reg  [NUM_CHANNELS];
    logic [WID_W-1:0]  width_next [NUM_CHANNELS];

    logic              vld_reg, vld_next;
    chan_result_t      res_reg, res_next;

    logic              take;
    logic              is_cap;
    logic [31:0]       ch_wide;
    logic [CAP_W-1:0]  cap_m;
    logic [CAP_W-1:0]  sel_start;
    logic [OVF_W-1:0]  sel_ovf;
    logic [63:0]       ovf_shift;
    logic [WID_W-1:0]  new_width;
    logic [CH_W-1:0]   rep_ch;
    logic [31:0]       rep_wide;
    logic [WID_W-1:0]  rep_width;

    assign in_ready  = !vld_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign out_res   = res_reg;

    always_comb begin
        ch_wide   = {{(32-CH_W){1'b0}}, in_evt.channel};
        cap_m     = in_evt.capture_value & CAP_MASK;
        is_cap    = (in_evt.action == ACT_CAPTURE) && (ch_wide < 32'(NUM_CHANNELS));

        // select the capturing channel's stored state
        sel_start = start_reg[0];
        sel_ovf   = ovf_reg[0];
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (ch_wide == 32'(i)) begin
                sel_start = start_reg[i];
                sel_ovf   = ovf_reg[i];
            end
        end
        ovf_shift = 64'(sel_ovf) << COUNTER_BITS;
        new_width = WID_W'(cap_m) - WID_W'(sel_start) + ovf_shift[WID_W-1:0];

        for (int i = 0; i < NUM_CHANNELS; i++) begin
            start_next[i] = start_reg[i];
            ovf_next[i]   = ovf_reg[i];
            width_next[i] = width_reg[i];
            if (take) begin
                if (in_evt.action == ACT_OVERFLOW) begin
                    if (ovf_reg[i] != OVF_MAX) begin
                        ovf_next[i] = ovf_reg[i] + {{(OVF_W-1){1'b0}}, 1'b1};
                    end
                end else if (is_cap && (ch_wide == 32'(i))) begin
                    if (in_evt.pin_level) begin
                        start_next[i] = cap_m;
                    end else begin
                        width_next[i] = new_width;
                        ovf_next[i]   = '0;
                    end
                end
            end
        end

        // report the capturing channel, else channel 0
        rep_ch    = is_cap ? in_evt.channel : '0;
        rep_wide  = {{(32-CH_W){1'b0}}, rep_ch};
        rep_width = width_next[0];
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (rep_wide == 32'(i)) begin
                rep_width = width_next[i];
            end
        end

        vld_next = vld_reg;
        res_next = res_reg;
        if (in_ready) begin
            vld_next = in_valid;
        end
        if (take) begin
            res_next.out_channel = rep_ch;
            res_next.width_ticks = rep_width;
            res_next.measured    = is_cap && !in_evt.pin_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                start_reg[i] <= '0;
                ovf_reg[i]   <= '0;
                width_reg[i] <= '0;
            end
        end else begin
            vld_reg <= vld_next;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                start_reg[i] <= start_next[i];
                ovf_reg[i]   <= ovf_next[i];
                width_reg[i] <= width_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            widths[i] = width_reg[i];
        end
    end

    // an overflow tick reports channel 0 with no new measurement
    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (in_evt.action == ACT_OVERFLOW)
        |=> vld_reg && !res_reg.measured && (res_reg.out_channel == '0))
        else $error("overflow tick produced a measurement");

endmodule
`default_nettype wire

### rtl/core/epc_zone.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epc_zone
// Nearest valid width across channels, classified into a beep zone.
// Registers the final result beat.
// ----------------------------------------------------------------------------
module epc_zone #(
    parameter int NUM_CHANNELS = 3
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    input  wire epc_pkg::chan_result_t        in_res,
    output logic                              in_ready,
    input  wire logic [epc_pkg::WID_W-1:0]    widths [NUM_CHANNELS],
    input  wire epc_pkg::zone_cfg_t           cfg,
    output logic                              out_valid,
    output epc_pkg::chan_result_t             out_res,
    output logic [2:0]                        out_zone,
    input  wire logic                         out_ready
);
    import epc_pkg::*;

    logic              vld_reg, vld_next;
    chan_result_t      res_reg, res_next;
    zone_t             zone_reg, zone_next;

    logic              take;
    logic              any_valid;
    logic [WID_W-1:0]  best;
    zone_t             zone_calc;

    assign in_ready  = !vld_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign out_res   = res_reg;
    assign out_zone  = zone_reg;

    always_comb begin
        any_valid = 1'b0;
        best      = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if ((widths[i] >= cfg.min_valid) && (widths[i] < cfg.max_valid)) begin
                if (!any_valid || (widths[i] < best)) begin
                    best = widths[i];
                end
                any_valid = 1'b1;
            end
        end

        if (!cfg.active) begin
            zone_calc = ZONE_SILENT;
        end else if (!any_valid) begin
            zone_calc = ZONE_NONE;
        end else if (best < cfg.near_limit) begin
            zone_calc = ZONE_NEAR;
        end else if (best < cfg.mid_limit) begin
            zone_calc = ZONE_MID;
        end else if (best < cfg.far_limit) begin
            zone_calc = ZONE_FAR;
        end else begin
            zone_calc = ZONE_SILENT;
        end

        vld_next  = vld_reg;
        res_next  = res_reg;
        zone_next = zone_reg;
        if (in_ready) begin
            vld_next = in_valid;
        end
        if (take) begin
            res_next  = in_res;
            zone_next = zone_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        zone_reg <= zone_next;
    end

    a_silent_when_off: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !cfg.active |=> zone_reg == ZONE_SILENT)
        else $error("zone not silent with classification disabled");

    a_valid_measure_zoned: assert property (@(posedge aclk) disable iff (!aresetn)
        take && cfg.active && in_res.measured
        && (in_res.width_ticks >= cfg.min_valid) && (in_res.width_ticks < cfg.max_valid)
        |=> zone_reg != ZONE_NONE)
        else $error("valid new width reported as no valid channel");

endmodule
`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Echo pulse capture and zoning testbench
// Drives overflow ticks and echo captures into the block and predicts every
// result beat in a local copy of the channel state and zone registers.
// Reset state, directed, overflow run, backpressure and random register phases follow in turn.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import epc_pkg::*;

    localparam int NCH         = 3;
    localparam int PIPE_LAT    = 3;     // allowance for the registered pipeline stages when draining
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int STUCK_LIMIT = 3000;  // cycles without any beat before giving up
    localparam int PHASE_EVENTS = 160;
    localparam int TICK_RUN    = 200;   // overflow ticks in the gap-free run

    // One predicted result beat
    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [WID_W-1:0] width;
        logic             measured;
        zone_t            zone;
    } echo_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    echo_pulse_capture_proximity_zone_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Local copy of the block's state and zoning registers
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] start_q [NCH];
    logic [OVF_W-1:0] ovf_q   [NCH];
    logic [WID_W-1:0] width_q [NCH];
    logic             zone_active;
    logic [WID_W-1:0] lim_min, lim_max, lim_near, lim_mid, lim_far;

    echo_result_t pending_results[$];

    // Run statistics and control flags
    int mismatches     = 0;
    int events_sent    = 0;
    int ignored_sent   = 0;
    int results_seen   = 0;
    int widths_seen    = 0;
    int stalled_cycles = 0;
    int stuck_cycles   = 0;
    int zone_hits[5]   = '{default: 0};
    bit no_idle        = 0;   // both sides run without gaps while set
    bit hold_request   = 0;   // ask the receiver for one long hold-off

    function automatic void reset_model();
        for (int i = 0; i < NCH; i++) begin
            start_q[i] = '0;
            ovf_q[i]   = '0;
            width_q[i] = '0;
        end
        zone_active = 1'b0;
        lim_min  = RST_MIN_VALID;
        lim_max  = RST_MAX_VALID;
        lim_near = RST_NEAR;
        lim_mid  = RST_MID;
        lim_far  = RST_FAR;
    endfunction

    // Nearest valid width decides the beep zone
    function automatic zone_t classify_zone();
        logic             found;
        logic [WID_W-1:0] best;
        found = 1'b0;
        best  = '0;
        if (!zone_active) return ZONE_SILENT;
        for (int i = 0; i < NCH; i++) begin
            if (width_q[i] >= lim_min && width_q[i] < lim_max) begin
                if (!found || width_q[i] < best) best = width_q[i];
                found = 1'b1;
            end
        end
        if (!found) return ZONE_NONE;
        if (best < lim_near) return ZONE_NEAR;
        if (best < lim_mid) return ZONE_MID;
        if (best < lim_far) return ZONE_FAR;
        return ZONE_SILENT;
    endfunction

    // Advance the local state by one event and return the beat it causes
    function automatic echo_result_t capture_step(action_t act, logic [1:0] ch,
                                                  logic lvl, logic [15:0] cap);
        echo_result_t r;
        int           rep;
        logic [31:0]  span;
        rep        = 0;
        r.measured = 1'b0;
        if (act == ACT_OVERFLOW) begin
            for (int i = 0; i < NCH; i++)
                if (ovf_q[i] != OVF_MAX) ovf_q[i] = ovf_q[i] + 1'b1;
        end else if (ch < NCH) begin
            rep = ch;
            if (lvl) begin
                start_q[ch] = cap;
            end else begin
                span = {16'h0, cap} - {16'h0, start_q[ch]} + {ovf_q[ch], 16'h0};
                width_q[ch] = span;
                ovf_q[ch]   = '0;
                r.measured  = 1'b1;
            end
        end
        r.ch    = rep[1:0];
        r.width = width_q[rep];
        r.zone  = classify_zone();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock and result checking
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Compare each result beat with the oldest prediction, field by field
    always @(posedge aclk) begin
        echo_result_t exp_beat;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction waiting: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                exp_beat = pending_results.pop_front();
                if (exp_beat.measured) widths_seen++;
                zone_hits[exp_beat.zone]++;
                if (m_axis_tdata[1:0] !== exp_beat.ch) begin
                    $error("out_channel: expected %0d, got %0d", exp_beat.ch,
                           m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[33:2] !== exp_beat.width) begin
                    $error("width_ticks: expected %0d, got %0d", exp_beat.width,
                           m_axis_tdata[33:2]);
                    mismatches++;
                end
                if (m_axis_tuser !== exp_beat.measured) begin
                    $error("measured: expected %0d, got %0d", exp_beat.measured,
                           m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[36:34] !== exp_beat.zone) begin
                    $error("zone: expected %0d, got %0d", exp_beat.zone,
                           m_axis_tdata[36:34]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && !s_axis_tready) stalled_cycles++;
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Result receiver: random stalls, a gap-free mode, and one long hold-off
    // counted here so the sender keeps offering beats while the pipe fills.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 0;
            end
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 31);
        end
    end

    // ------------------------------------------------------------------
    // Drivers: every task starts and ends at a falling edge
    // ------------------------------------------------------------------

    // Offer one event beat; valid stays high on return so back-to-back beats
    // need only one assignment per step.
    task automatic send_event(action_t act, logic [1:0] ch, logic lvl, logic [15:0] cap);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 31) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'b0, cap, lvl, ch};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_results.push_back(capture_step(act, ch, lvl, cap));
        if (act == ACT_CAPTURE && ch >= NCH) ignored_sent++;
        else events_sent++;
        @(negedge aclk);
    endtask

    // Drop valid, wait for every prediction to be matched, then let the pipe empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 4) @(negedge aclk);
    endtask

    // One register beat; valid is left high for a following write
    task automatic push_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_ACTIVE:    zone_active = val[0];
            CFG_MIN_VALID: lim_min  = val;
            CFG_MAX_VALID: lim_max  = val;
            CFG_NEAR:      lim_near = val;
            CFG_MID:       lim_mid  = val;
            CFG_FAR:       lim_far  = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Load all zoning registers; only call while the block is idle
    task automatic program_regs(logic act, logic [31:0] mn, logic [31:0] mx,
                                logic [31:0] nr, logic [31:0] md, logic [31:0] fr);
        push_reg(CFG_ACTIVE, {31'b0, act});
        push_reg(CFG_MIN_VALID, mn);
        push_reg(CFG_MAX_VALID, mx);
        push_reg(CFG_NEAR, nr);
        push_reg(CFG_MID, md);
        push_reg(CFG_FAR, fr);
        cfg_valid <= 1'b0;
    endtask

    // Pulse length in ticks, biased toward the current zone boundaries
    function automatic logic [15:0] pick_span();
        logic [31:0] edge_pick;
        case ($urandom_range(0, 4))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0: edge_pick = lim_min;
                    1: edge_pick = lim_max;
                    2: edge_pick = lim_near;
                    3: edge_pick = lim_mid;
                    default: edge_pick = lim_far;
                endcase
                if (edge_pick > 32'd65537) return 16'($urandom_range(0, 65535));
                return 16'(edge_pick + $urandom_range(0, 4) - 2);
            end
            2: return 16'($urandom_range(0, 300));
            3: return 16'($urandom_range(0, 30000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly complete rise/fall pairs, with a tick where the counter wraps;
    // the rest is loose ticks, unmatched edges and out-of-range channels.
    task automatic run_random_events(int n_events);
        int          target;
        logic [1:0]  ch;
        logic [15:0] t0, span;
        target = events_sent + n_events;
        while (events_sent < target) begin
            if ($urandom_range(0, 99) < 70) begin
                ch   = 2'($urandom_range(0, NCH - 1));
                t0   = 16'($urandom_range(0, 65535));
                span = pick_span();
                send_event(ACT_CAPTURE, ch, 1'b1, t0);
                if ({1'b0, t0} + {1'b0, span} > 17'hFFFF || $urandom_range(0, 9) == 0)
                    send_event(ACT_OVERFLOW, 2'($urandom_range(0, 3)), 1'($urandom),
                               16'($urandom));
                send_event(ACT_CAPTURE, ch, 1'b0, t0 + span);
            end else if ($urandom_range(0, 2) == 0) begin
                send_event(ACT_OVERFLOW, 2'($urandom_range(0, 3)), 1'($urandom),
                           16'($urandom));
            end else begin
                send_event(ACT_CAPTURE, 2'($urandom_range(0, 3)), 1'($urandom),
                           16'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at their reset values: zoning is off, so every zone is silence
    task automatic test_reset_state();
        send_event(ACT_OVERFLOW, 2'd0, 1'b0, 16'h0000);
        send_event(ACT_CAPTURE, 2'd0, 1'b1, 16'd10);
        send_event(ACT_CAPTURE, 2'd0, 1'b0, 16'd1000);
        drain();
    endtask

    // Field extremes, every channel, unmatched falls, wraps and boundary widths
    task automatic test_directed_edges();
        program_regs(1'b1, RST_MIN_VALID, RST_MAX_VALID, RST_NEAR, RST_MID, RST_FAR);
        send_event(ACT_CAPTURE, 2'd0, 1'b1, 16'h0000);
        send_event(ACT_CAPTURE, 2'd0, 1'b0, 16'hFFFF);      // widest single period
        send_event(ACT_CAPTURE, 2'd1, 1'b1, 16'd100);
        send_event(ACT_CAPTURE, 2'd1, 1'b0, 16'd216);       // exactly the minimum
        send_event(ACT_CAPTURE, 2'd2, 1'b0, 16'd2900);      // fall with no rise
        send_event(ACT_CAPTURE, 2'd3, 1'b1, 16'hFFFF);      // channel out of range
        send_event(ACT_CAPTURE, 2'd3, 1'b0, 16'h0000);
        send_event(ACT_OVERFLOW, 2'd3, 1'b1, 16'hFFFF);     // tick with junk fields
        send_event(ACT_CAPTURE, 2'd2, 1'b1, 16'hFFF0);
        send_event(ACT_OVERFLOW, 2'd0, 1'b0, 16'h0000);
        send_event(ACT_CAPTURE, 2'd2, 1'b0, 16'h0010);      // across a wrap
        send_event(ACT_CAPTURE, 2'd1, 1'b1, 16'd500);
        send_event(ACT_CAPTURE, 2'd1, 1'b0, 16'd23699);     // just below the maximum
        send_event(ACT_CAPTURE, 2'd1, 1'b1, 16'd500);
        send_event(ACT_CAPTURE, 2'd1, 1'b0, 16'd23700);     // at the maximum
        send_event(ACT_CAPTURE, 2'd0, 1'b1, 16'd1000);
        send_event(ACT_CAPTURE, 2'd0, 1'b0, 16'd999);       // end before start
        send_event(ACT_CAPTURE, 2'd2, 1'b1, 16'h5555);
        send_event(ACT_CAPTURE, 2'd2, 1'b0, 16'hAAAA);
        send_event(ACT_CAPTURE, 2'd0, 1'b1, 16'd0);
        send_event(ACT_CAPTURE, 2'd0, 1'b0, 16'd5800);
        drain();
    endtask

    // Long tick run adds many periods to every channel; no gaps on either side
    task automatic test_overflow_run();
        no_idle = 1;
        send_event(ACT_CAPTURE, 2'd1, 1'b1, 16'h1234);
        repeat (TICK_RUN) send_event(ACT_OVERFLOW, 2'd0, 1'b0, 16'h0000);
        send_event(ACT_CAPTURE, 2'd1, 1'b0, 16'h1233);
        send_event(ACT_CAPTURE, 2'd0, 1'b0, 16'hFFFF);
        send_event(ACT_CAPTURE, 2'd2, 1'b0, 16'h0000);
        no_idle = 0;
        drain();
    endtask

    // Receiver holds off while events keep coming, so the input stalls
    task automatic test_backpressure();
        hold_request = 1;
        run_random_events(40);
        drain();
    endtask

    // Random traffic under a series of register settings, extremes included
    task automatic test_random_phases();
        logic [31:0] mn, nr, md, fr;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: program_regs(1'b1, RST_MIN_VALID, RST_MAX_VALID, RST_NEAR, RST_MID,
                                RST_FAR);
                1: program_regs(1'b0, RST_MIN_VALID, RST_MAX_VALID, RST_NEAR, RST_MID,
                                RST_FAR);
                2: program_regs(1'b1, '0, '0, '0, '0, '0);
                3: program_regs(1'b1, '0, '1, '1, '1, '1);
                4: program_regs(1'b1, '1, '1, '0, '1, '0);
                5: begin
                    mn = $urandom_range(0, 400);
                    nr = mn + $urandom_range(0, 8000);
                    md = nr + $urandom_range(0, 8000);
                    fr = md + $urandom_range(0, 8000);
                    program_regs(1'b1, mn, $urandom_range(fr, 60000), nr, md, fr);
                end
                default: program_regs(1'($urandom), $urandom, $urandom, $urandom,
                                      $urandom, $urandom);
            endcase
            run_random_events(PHASE_EVENTS);
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Hold every input at a known value from time zero
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        reset_model();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_directed_edges();
        test_overflow_run();
        test_backpressure();
        test_random_phases();

        drain();
        $display("Covered %0d events plus %0d out-of-range captures, %0d results, %0d widths",
                 events_sent, ignored_sent, results_seen, widths_seen);
        $display("Zones none/near/mid/far/silent: %0d/%0d/%0d/%0d/%0d, input stalled %0d cycles",
                 zone_hits[0], zone_hits[1], zone_hits[2], zone_hits[3], zone_hits[4],
                 stalled_cycles);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/epc_pkg.sv
rtl/core/epc_chan.sv
rtl/core/epc_zone.sv
rtl/core/echo_pulse_capture_proximity_zone_top.sv
bench/testbench.sv
